/* hw/rtl/tcgr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_pkg
// shared constants, codes, widths and the fixed color palette of the glyph renderer
// ----------------------------------------------------------------------------
package tcgr_pkg;

  // default geometry of the font store and glyph cells
  localparam int unsigned DEF_FONT_DEPTH   = 4096;
  localparam int unsigned DEF_GLYPH_HEIGHT = 16;
  localparam int unsigned MAX_DIMENSION    = 4096;

  // payload widths
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned FIDX_W  = 12;
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned CMP_W   = 14;
  localparam int unsigned PITCH_W = 16;
  localparam int unsigned STRD_W  = 14;
  localparam int unsigned PAL_W   = 4;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDAT_W  = 32;

  // input actions
  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // control characters
  localparam logic [CODE_W-1:0] CH_NL = 8'd10;
  localparam logic [CODE_W-1:0] CH_CR = 8'd13;

  // result kinds
  localparam logic KIND_ROW  = 1'b0;
  localparam logic KIND_FILL = 1'b1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_BASE   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_WIDTH  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_PITCH  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_FG     = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_BG     = 3'd5;

  // configuration reset values
  localparam logic [ADDR_W-1:0]  RST_BASE   = 32'h0000_0000;
  localparam logic [DIM_W-1:0]   RST_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]   RST_HEIGHT = 13'd480;
  localparam logic [PITCH_W-1:0] RST_PITCH  = 16'd2560;
  localparam logic [PAL_W-1:0]   RST_FG     = 4'hF;
  localparam logic [PAL_W-1:0]   RST_BG     = 4'h0;

  // 16-entry text-mode palette
  function automatic logic [COLOR_W-1:0] palette_color(input logic [PAL_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'h0000AA;
      4'd2:    c = 24'h00AA00;
      4'd3:    c = 24'h00AAAA;
      4'd4:    c = 24'hAA0000;
      4'd5:    c = 24'hAA00AA;
      4'd6:    c = 24'hAA5500;
      4'd7:    c = 24'hAAAAAA;
      4'd8:    c = 24'h555555;
      4'd9:    c = 24'h5555FF;
      4'd10:   c = 24'h55FF55;
      4'd11:   c = 24'h55FFFF;
      4'd12:   c = 24'hFF5555;
      4'd13:   c = 24'hFF55FF;
      4'd14:   c = 24'hFFFF55;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/tcgr_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr channel interfaces
// valid/ready channels for input items, drawing results and register writes
// ----------------------------------------------------------------------------
interface tcgr_in_if import tcgr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [CODE_W-1:0]   char_code;
  logic [FIDX_W-1:0]   font_index;
  logic [CODE_W-1:0]   font_byte;

  modport source(output valid, action, char_code, font_index, font_byte, input ready);
  modport sink(input valid, action, char_code, font_index, font_byte, output ready);
endinterface

interface tcgr_out_if import tcgr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [PIX_W-1:0]    pixel_x;
  logic [PIX_W-1:0]    pixel_y;
  logic [ADDR_W-1:0]   byte_address;
  logic [7:0]          glyph_bits;
  logic [7:0]          column_mask;
  logic [COLOR_W-1:0]  fg_color;
  logic [COLOR_W-1:0]  bg_color;
  logic                last;

  modport source(output valid, kind, pixel_x, pixel_y, byte_address, glyph_bits,
                 column_mask, fg_color, bg_color, last, input ready);
  modport sink(input valid, kind, pixel_x, pixel_y, byte_address, glyph_bits,
               column_mask, fg_color, bg_color, last, output ready);
endinterface

interface tcgr_cfg_if import tcgr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CIDX_W-1:0]   index;
  logic [CDAT_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/text_console_glyph_renderer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_unit
// text-mode character generator: font store, cursor and glyph row sequencer
// an item's first result passes the sequencer, the row stage and the output register
// throughput: one result per cycle unless the output stalls, bound by the single
//   font store read port; a drawn character gives one result per visible glyph
//   row (GLYPH_HEIGHT max); a screen clear adds one fill result
// reset: synchronous active-low, clears cursor, config and pipeline, not the font store
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_unit import tcgr_pkg::*; #(
  parameter int unsigned FONT_DEPTH   = DEF_FONT_DEPTH,
  parameter int unsigned GLYPH_HEIGHT = DEF_GLYPH_HEIGHT
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tcgr_in_if.sink     in_ch,
  tcgr_out_if.source  out_ch,
  tcgr_cfg_if.sink    cfg_ch
);

  localparam int unsigned FA_W   = $clog2(FONT_DEPTH);
  localparam int unsigned IW     = $clog2(GLYPH_HEIGHT);
  localparam int unsigned CV_W   = $clog2(256 * GLYPH_HEIGHT);
  localparam int unsigned MW     = (CV_W > FA_W + 1) ? CV_W : FA_W + 1;
  localparam int unsigned FI_W   = (FA_W + 1 > FIDX_W) ? FA_W + 1 : FIDX_W;
  localparam int unsigned MOD_STEPS = (256 * GLYPH_HEIGHT - 1) / FONT_DEPTH;
  localparam int unsigned PROD_W = CMP_W + STRD_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROWS  = 3'b010,
    ST_CLEAR = 3'b100
  } seq_state_t;

  // configuration
  logic [ADDR_W-1:0]  base_r;
  logic [DIM_W-1:0]   sw_r, sh_r;
  logic [PITCH_W-1:0] pitch_r;
  logic [PAL_W-1:0]   fg_r, bg_r;
  logic [CMP_W-1:0]   width_c, height_c;
  logic [STRD_W-1:0]  stride;

  // cursor and sequencer
  logic [DIM_W-1:0]   col_r, col_nxt, row_r, row_nxt;
  seq_state_t         state_r, state_nxt;
  logic [IW-1:0]      i_r, i_nxt;
  logic [DIM_W-1:0]   rs_r, rs_nxt, cs_r, cs_nxt;
  logic [FA_W-1:0]    fa_r, fa_nxt;
  logic               clr_r, clr_nxt;

  // font store
  logic [7:0]         font_mem [FONT_DEPTH];
  logic [7:0]         font_q_r;
  logic               rd_en, wr_en;
  logic [FI_W-1:0]    wr_idx;
  logic [FA_W:0]      fa_inc;
  logic [FA_W-1:0]    fa_step;
  logic [MW-1:0]      fa_init;

  // decode
  logic               in_acc, in_rdy, out_en, en_o, en_1;
  logic               is_put, is_clr, is_nl, is_cr, printable, enabled;
  logic [CMP_W-1:0]   col_a;
  logic               wrap, fits, new_clr;
  logic [CMP_W:0]     row_a;
  logic [DIM_W-1:0]   row_m, col_m;

  // row issue
  logic [CMP_W-1:0]   row_y;
  logic               more, final_emit;
  logic               iss_vld, iss_kind, iss_last;
  logic [CMP_W-1:0]   iss_y;
  logic [DIM_W-1:0]   iss_x;
  logic [7:0]         iss_mask, col_mask;

  // pipeline stage and output register
  logic               s1_vld_r, s1_kind_r, s1_last_r;
  logic [DIM_W-1:0]   s1_x_r;
  logic [PIX_W-1:0]   s1_y_r;
  logic [PROD_W-1:0]  s1_prod_r;
  logic [7:0]         s1_mask_r;
  logic [PROD_W:0]    s1_sum;

  logic               out_vld_r, out_kind_r, out_last_r;
  logic [PIX_W-1:0]   out_x_r, out_y_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [7:0]         out_bits_r, out_mask_r;

  // configuration port
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= RST_BASE;
      sw_r    <= RST_WIDTH;
      sh_r    <= RST_HEIGHT;
      pitch_r <= RST_PITCH;
      fg_r    <= RST_FG;
      bg_r    <= RST_BG;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_BASE:   base_r  <= cfg_ch.data;
        CFG_WIDTH:  sw_r    <= cfg_ch.data[DIM_W-1:0];
        CFG_HEIGHT: sh_r    <= cfg_ch.data[DIM_W-1:0];
        CFG_PITCH:  pitch_r <= cfg_ch.data[PITCH_W-1:0];
        CFG_FG:     fg_r    <= cfg_ch.data[PAL_W-1:0];
        CFG_BG:     bg_r    <= cfg_ch.data[PAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign width_c  = ({1'b0, sw_r} > CMP_W'(MAX_DIMENSION)) ? CMP_W'(MAX_DIMENSION)
                                                           : {1'b0, sw_r};
  assign height_c = ({1'b0, sh_r} > CMP_W'(MAX_DIMENSION)) ? CMP_W'(MAX_DIMENSION)
                                                           : {1'b0, sh_r};
  assign stride   = pitch_r[PITCH_W-1:2];

  // handshakes
  assign en_o    = !out_vld_r || out_ch.ready;
  assign en_1    = !s1_vld_r || en_o;
  assign out_en  = en_o;
  assign in_rdy  = (state_r == ST_IDLE) || final_emit;
  assign in_ch.ready = in_rdy;
  assign in_acc  = in_ch.valid && in_rdy;

  // item decode
  assign is_put    = (in_ch.action == ACT_PUT);
  assign is_clr    = (in_ch.action == ACT_CLEAR);
  assign is_nl     = (in_ch.char_code == CH_NL);
  assign is_cr     = (in_ch.char_code == CH_CR);
  assign printable = !is_nl && !is_cr;
  assign enabled   = (base_r != '0);
  assign wr_en     = in_acc && (in_ch.action == ACT_LOAD);

  assign col_a = printable ? ({1'b0, col_r} + CMP_W'(8)) : '0;
  assign wrap  = (col_a >= width_c);
  assign row_a = {2'b00, row_r} + (is_nl ? (CMP_W+1)'(GLYPH_HEIGHT) : '0)
                                + (wrap  ? (CMP_W+1)'(GLYPH_HEIGHT) : '0);
  assign row_m = row_a[DIM_W-1:0];
  assign col_m = wrap ? '0 : col_a[DIM_W-1:0];
  assign fits  = (({1'b0, row_m} + CMP_W'(GLYPH_HEIGHT)) < height_c);
  assign new_clr = is_clr || (is_put && !fits);

  // font store index reduction
  always_comb begin
    fa_init = MW'(in_ch.char_code) * MW'(GLYPH_HEIGHT);
    for (int k = 0; k < MOD_STEPS; k++) begin
      if (fa_init >= MW'(FONT_DEPTH)) begin
        fa_init = fa_init - MW'(FONT_DEPTH);
      end
    end
    wr_idx = FI_W'(in_ch.font_index);
    if (wr_idx >= FI_W'(FONT_DEPTH)) begin
      wr_idx = wr_idx - FI_W'(FONT_DEPTH);
    end
  end

  assign fa_inc  = {1'b0, fa_r} + (FA_W+1)'(1);
  assign fa_step = (fa_inc == (FA_W+1)'(FONT_DEPTH)) ? '0 : fa_inc[FA_W-1:0];

  // row issue
  assign row_y = {1'b0, rs_r} + CMP_W'(i_r);
  assign more  = (i_r != IW'(GLYPH_HEIGHT - 1)) &&
                 (((CMP_W+1)'(row_y) + (CMP_W+1)'(1)) < (CMP_W+1)'(height_c));

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      col_mask[7-j] = (({1'b0, cs_r} + CMP_W'(j)) < width_c);
    end
  end

  assign final_emit = en_1 && (((state_r == ST_ROWS) && !more && !clr_r) ||
                               (state_r == ST_CLEAR));
  assign iss_vld  = (state_r == ST_ROWS) || (state_r == ST_CLEAR);
  assign iss_kind = (state_r == ST_CLEAR) ? KIND_FILL : KIND_ROW;
  assign iss_y    = (state_r == ST_ROWS) ? row_y : '0;
  assign iss_x    = (state_r == ST_ROWS) ? cs_r : '0;
  assign iss_mask = (state_r == ST_ROWS) ? col_mask : '0;
  assign iss_last = (state_r == ST_ROWS) ? (!more && !clr_r) : 1'b1;
  assign rd_en    = en_1 && (state_r == ST_ROWS);

  // sequencer and cursor next state
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    rs_nxt    = rs_r;
    cs_nxt    = cs_r;
    fa_nxt    = fa_r;
    clr_nxt   = clr_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    case (state_r)
      ST_ROWS: begin
        if (en_1) begin
          if (more) begin
            i_nxt  = i_r + IW'(1);
            fa_nxt = fa_step;
          end else if (clr_r) begin
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CLEAR: begin
        if (en_1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
    if (in_acc) begin
      state_nxt = ST_IDLE;
      i_nxt     = '0;
      rs_nxt    = row_r;
      cs_nxt    = col_r;
      fa_nxt    = fa_init[FA_W-1:0];
      clr_nxt   = new_clr;
      if (enabled && (is_put || is_clr)) begin
        col_nxt = new_clr ? '0 : col_m;
        row_nxt = new_clr ? '0 : row_m;
        if (is_put && printable && ({1'b0, row_r} < height_c)) begin
          state_nxt = ST_ROWS;
        end else if (new_clr) begin
          state_nxt = ST_CLEAR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      clr_r   <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      clr_r   <= clr_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rs_r <= rs_nxt;
    cs_r <= cs_nxt;
    fa_r <= fa_nxt;
  end

  // font store, read-first
  always_ff @(posedge clk) begin
    if (rd_en) begin
      font_q_r <= font_mem[fa_r];
    end
    if (wr_en) begin
      font_mem[wr_idx[FA_W-1:0]] <= in_ch.font_byte;
    end
  end

  // row stage: address product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en_1) begin
      s1_vld_r <= iss_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_1) begin
      s1_kind_r <= iss_kind;
      s1_last_r <= iss_last;
      s1_x_r    <= iss_x;
      s1_y_r    <= iss_y[PIX_W-1:0];
      s1_mask_r <= iss_mask;
      s1_prod_r <= PROD_W'(iss_y) * PROD_W'(stride);
    end
  end

  assign s1_sum = {1'b0, s1_prod_r} + (PROD_W+1)'(s1_x_r);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_en) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_kind_r <= s1_kind_r;
      out_last_r <= s1_last_r;
      out_x_r    <= s1_x_r[PIX_W-1:0];
      out_y_r    <= s1_y_r;
      out_mask_r <= s1_mask_r;
      out_bits_r <= (s1_kind_r == KIND_FILL) ? '0 : font_q_r;
      out_addr_r <= base_r + ADDR_W'({s1_sum, 2'b00});
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.pixel_x      = out_x_r;
  assign out_ch.pixel_y      = out_y_r;
  assign out_ch.byte_address = out_addr_r;
  assign out_ch.glyph_bits   = out_bits_r;
  assign out_ch.column_mask  = out_mask_r;
  assign out_ch.fg_color     = palette_color(fg_r);
  assign out_ch.bg_color     = palette_color(bg_r);
  assign out_ch.last         = out_last_r;

`ifndef SYNTH
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !en_1) |=> ($stable(s1_prod_r) && $stable(s1_last_r) && $stable(s1_kind_r)))
    else $error("row stage changed while stalled");

  a_fill_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_kind_r == KIND_FILL)) |-> out_last_r)
    else $error("fill command not marked last");

  a_fill_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && (s1_kind_r == KIND_FILL)) |-> ((s1_prod_r == '0) && (s1_x_r == '0)))
    else $error("fill command has nonzero offset");
`endif

endmodule
`default_nettype wire
